// ===== rtl/core/prhm_pkg.sv =====
// Shared widths, limits and helper functions of the packed row mirror.
package prhm_pkg;

    localparam int MAX_ROW_BYTES = 64;
    localparam int BYTE_W        = 8;
    localparam int CFG_W         = 7;
    localparam int ROW_IDX_W     = $clog2(MAX_ROW_BYTES);

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [CFG_W-1:0]     t_cfg;
    typedef logic [ROW_IDX_W-1:0] t_row_idx;

    // Swap nibbles, then bit pairs, then single bits.
    function automatic t_byte bit_reverse(input t_byte v);
        t_byte b;
        b = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
        b = ((b & 8'hCC) >> 2) | ((b & 8'h33) << 2);
        b = ((b & 8'hAA) >> 1) | ((b & 8'h55) << 1);
        return b;
    endfunction

    // Clamp the register to 1..MAX_ROW_BYTES.
    function automatic t_cfg effective_row(input t_cfg rb);
        t_cfg n;
        n = rb;
        if (n == '0) begin
            n = t_cfg'(1);
        end
        if (n > t_cfg'(MAX_ROW_BYTES)) begin
            n = t_cfg'(MAX_ROW_BYTES);
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/prhm_if.sv =====
// Valid/ready stream interfaces for input and output words of the row mirror.
interface prhm_in_if;
    logic            valid;
    logic            ready;
    prhm_pkg::t_byte in_byte;
    logic            in_frame_end;

    modport source (output valid, output in_byte, output in_frame_end, input ready);
    modport sink   (input valid, input in_byte, input in_frame_end, output ready);
endinterface

interface prhm_out_if;
    logic            valid;
    logic            ready;
    prhm_pkg::t_byte out_byte;
    logic            out_row_end;

    modport source (output valid, output out_byte, output out_row_end, input ready);
    modport sink   (input valid, input out_byte, input out_row_end, output ready);
endinterface

// ===== rtl/core/packed_row_horizontal_mirror_unit.sv =====
// Top level: collects packed 1bpp bytes into a row store and emits each row mirrored.
// Usage:
//   i_in carries one packed byte per word (MSB is the leftmost pixel) plus a
//   frame-end flag. Bytes fill a 64-entry row store. The byte that completes a
//   row of the configured length starts the readout: the row leaves on o_out
//   last byte first, each byte bit-reversed, with out_row_end set on the final
//   word of the row. A frame-end word is stored first (it may complete a row),
//   then any partial row is dropped and the fill count returns to zero.
//   The config channel (i_cfg_valid/o_cfg_ready/i_cfg_data) writes row_bytes;
//   zero acts as one, above 64 as 64, and every write drops the partial row.
// Timing:
//   A byte that does not complete a row is only stored; i_in stays ready
//   unless a config write is pending. A completing byte starts a readout of
//   n words, each a memory read, then a bit reverse into the output register,
//   and no further byte is taken until the last word is loaded. A small
//   sequencer steps the shared read port and bit reverser.
// Reset and stall:
//   Reset empties the row, drops any pending output and sets row_bytes to 64.
//   A stall on o_out holds the output register and the sequencer; the next
//   word is loaded only when the register is empty or being taken.
module packed_row_horizontal_mirror_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    prhm_in_if.sink            i_in,
    prhm_out_if.source         o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  prhm_pkg::t_cfg     i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    // Row store, written on accept, read one entry per readout step.
    prhm_pkg::t_byte r_mem [prhm_pkg::MAX_ROW_BYTES];

    logic [1:0]         r_state, n_state;
    prhm_pkg::t_cfg     r_row_bytes, n_row_bytes;
    prhm_pkg::t_row_idx r_fill, n_fill;
    prhm_pkg::t_row_idx r_rd_idx, n_rd_idx;
    prhm_pkg::t_byte    r_rd_data;
    logic               r_out_valid, n_out_valid;
    prhm_pkg::t_byte    r_out_byte, n_out_byte;
    logic               r_out_end, n_out_end;

    prhm_pkg::t_cfg     row_n;
    prhm_pkg::t_cfg     fill_next;
    logic               in_fire;
    logic               cfg_fire;
    logic               out_free;

    assign row_n     = prhm_pkg::effective_row(r_row_bytes);
    assign fill_next = prhm_pkg::t_cfg'(r_fill) + prhm_pkg::t_cfg'(1);

    // Config has priority over input in idle.
    assign o_cfg_ready = (r_state == S_IDLE);
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign i_in.ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.out_row_end = r_out_end;

    always_comb begin
        n_state     = r_state;
        n_row_bytes = r_row_bytes;
        n_fill      = r_fill;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_end   = r_out_end;

        // Drop the output word once taken.
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (cfg_fire) begin
                    n_row_bytes = i_cfg_data;
                    n_fill      = '0;
                end else if (in_fire) begin
                    if (fill_next >= row_n) begin
                        // Row complete: read back from the last byte.
                        n_fill   = '0;
                        n_rd_idx = prhm_pkg::t_row_idx'(row_n - prhm_pkg::t_cfg'(1));
                        n_state  = S_READ;
                    end else if (i_in.in_frame_end) begin
                        n_fill = '0;
                    end else begin
                        n_fill = prhm_pkg::t_row_idx'(fill_next);
                    end
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = prhm_pkg::bit_reverse(r_rd_data);
                    n_out_end   = (r_rd_idx == '0);
                    if (r_rd_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_rd_idx = r_rd_idx - prhm_pkg::t_row_idx'(1);
                        n_state  = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_bytes <= prhm_pkg::t_cfg'(prhm_pkg::MAX_ROW_BYTES);
            r_fill      <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_bytes <= n_row_bytes;
            r_fill      <= n_fill;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_end  <= n_out_end;
    end

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mem[r_fill] <= i_in.in_byte;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

endmodule

// ===== rtl/core/prhm_checker.sv =====
// Port-level checks of the row mirror and the bind that attaches them.
module prhm_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    prhm_in_if.sink      i_in,
    prhm_out_if.source   o_out
);

    // Hold a stalled output word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=>
            o_out.valid && $stable(o_out.out_byte) && $stable(o_out.out_row_end))
        else $error("stalled output word changed");

    // Mid-row output means readout still runs, so no input is taken.
    a_no_input_mid_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.out_row_end |-> !i_in.ready)
        else $error("input ready while a row is still being emitted");

    // A new output word comes only from the readout sequencer.
    a_out_from_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(!i_in.ready))
        else $error("output word appeared without a readout");

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

endmodule

bind packed_row_horizontal_mirror_unit prhm_checker u_prhm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);
